### design/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int BYTE_W        = 8;
   localparam int PATTERN_BYTES = 32;
   localparam int PATTERN_W     = PATTERN_BYTES * BYTE_W;
   localparam int CARE_W        = 32;
   localparam int LENGTH_W      = 6;
   localparam int ADDR_W        = 64;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_0_7   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_8_15  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARE_MASK     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS  = 3'd6;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 6'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_word_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_word_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [CARE_W-1:0]    care_mask;
      logic [LENGTH_W-1:0]  pattern_length;
      logic [ADDR_W-1:0]    base_address;
   } cfg_type;

endpackage

### design/wbps_csr.sv
// Configuration registers of the wildcard byte pattern scanner.
module wbps_csr
   import wbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_0_7:   cfg_in.pattern[0*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_PATTERN_8_15:  cfg_in.pattern[1*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_PATTERN_16_23: cfg_in.pattern[2*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_PATTERN_24_31: cfg_in.pattern[3*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_CARE_MASK:     cfg_in.care_mask      = csr_wdata[CARE_W-1:0];
            CSR_PATTERN_LEN:   cfg_in.pattern_length = csr_wdata[LENGTH_W-1:0];
            CSR_BASE_ADDRESS:  cfg_in.base_address   = csr_wdata[ADDR_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern        <= '0;
         cfg_ff.care_mask      <= '0;
         cfg_ff.pattern_length <= LENGTH_RESET;
         cfg_ff.base_address   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/wbps_engine.sv
// Byte window, region state and masked pattern compare.
module wbps_engine
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = 32,
   parameter int OFFSET_BITS     = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_word_type word,
   input  cfg_type      cfg,
   output logic         res_valid,
   output rsp_word_type res
);

   localparam int IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
   localparam logic [LENGTH_W-1:0] LEN_MAX = LENGTH_W'(MAX_PATTERN_LEN);

   logic [BYTE_W-1:0]      window_ff [MAX_PATTERN_LEN];
   logic [BYTE_W-1:0]      window_in [MAX_PATTERN_LEN];
   logic [OFFSET_BITS-1:0] pos_ff;
   logic [OFFSET_BITS-1:0] pos_in;
   logic                   done_ff;
   logic                   done_in;

   logic [LENGTH_W-1:0]    len_eff;
   logic [OFFSET_BITS-1:0] count;
   logic [OFFSET_BITS-1:0] offset;
   logic                   full;
   logic                   hit;

   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_eff = LENGTH_RESET;
      end else if (cfg.pattern_length > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = cfg.pattern_length;
      end
   end

   always_comb begin
      window_in[0] = word.data_byte;
      for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   assign count  = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;
   assign full   = count >= OFFSET_BITS'(len_eff);
   assign offset = count - OFFSET_BITS'(len_eff);

   always_comb begin
      logic [LENGTH_W-1:0] idx;
      logic                miss;
      miss = 1'b0;
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
         idx = len_eff - LENGTH_W'(1) - LENGTH_W'(k);
         if ((LENGTH_W'(k) < len_eff) && cfg.care_mask[k] &&
             (window_in[idx[IDX_W-1:0]] != cfg.pattern[BYTE_W*k +: BYTE_W])) begin
            miss = 1'b1;
         end
      end
      hit = full && !miss;
   end

   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      if (step) begin
         if (!done_ff) begin
            pos_in = count;
            if (hit) begin
               done_in = 1'b1;
            end
         end
         if (word.last_byte) begin
            pos_in  = '0;
            done_in = 1'b0;
         end
      end
   end

   always_comb begin
      res_valid         = step && !done_ff && (hit || word.last_byte);
      res.found         = hit;
      res.match_address = hit ?
         cfg.base_address + {{(ADDR_W-OFFSET_BITS){1'b0}}, offset} : '0;
   end

   always_ff @(posedge clock) begin
      if (step && !done_ff) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

`ifndef ASSERT_OFF
   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      step && word.last_byte |=> pos_ff == '0 && !done_ff)
      else $error("region state not cleared after last byte");

   a_done_by_hit: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(step && hit && !word.last_byte))
      else $error("done set without a match");

   a_quiet_after_match: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !res_valid)
      else $error("result after match in same region");

   a_pos_monotonic: assert property (@(posedge clock) disable iff (reset)
      step && !word.last_byte && !done_ff |=> pos_ff >= $past(pos_ff) && pos_ff != '0)
      else $error("position went backward inside a region");
`endif

endmodule

### design/wildcard_byte_pattern_scan_core.sv
// Top level of the wildcard byte pattern scanner.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   req_word_type
//   rsp      out        rsp_valid/rsp_stall   rsp_word_type
//   csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One word per cycle while rsp is not stalled: an input register feeds the window
// compare and a result register that drives rsp; a report is taken on a match or a region's last byte.
// Synchronous reset clears control, position, match flag and configuration;
// no clearing pass. The byte window is not reset: a compare only reads bytes
// of the current region. A stalled result holds and stalls the input register only.
module wildcard_byte_pattern_scan_core
   import wbps_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = 32,
   parameter int OFFSET_BITS     = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type      cfg;
   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;
   logic         advance;
   logic         consume;
   logic         accept;
   logic         res_valid;
   rsp_word_type res;

   assign csr_ready = 1'b1;

   wbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wbps_engine #(
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
      .OFFSET_BITS     (OFFSET_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (consume),
      .word      (in_word_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = consume && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (consume && res_valid) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### tb/tb_wildcard_byte_pattern_scan_core.sv
// Self-checking testbench for the wildcard byte pattern scanner core.
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scan_core;
   import wbps_pkg::*;

   localparam int                     CYCLE_LIMIT  = 200000;
   localparam int                     TAIL_CYCLES  = 12;
   localparam int                     PHASE_WORDS  = 100;
   localparam int                     PHASE_COUNT  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_stall;
   req_word_type     req_word   = '0;
   logic             rsp_valid;
   logic             rsp_stall  = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // scanner image: configuration
   logic [PATTERN_W-1:0] pattern_cfg = '0;
   logic [CARE_W-1:0]    care_cfg    = '0;
   logic [LENGTH_W-1:0]  length_cfg  = LENGTH_RESET;
   logic [ADDR_W-1:0]    base_cfg    = '0;

   // scanner image: region state
   logic [BYTE_W-1:0] window_bytes [PATTERN_BYTES];
   logic [31:0]       region_offset = '0;
   bit                region_matched = 1'b0;

   req_word_type scan_words [$];
   rsp_word_type predicted_reports [$];

   bit steady = 1'b0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int words_queued = 0;
   int words_accepted = 0;
   int regions_queued = 0;
   int reports_checked = 0;
   int reports_found = 0;
   int settings_loaded = 0;

   wildcard_byte_pattern_scan_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int active_length(input logic [LENGTH_W-1:0] raw);
      if (raw == 0) begin
         return 1;
      end
      if (raw > PATTERN_BYTES) begin
         return PATTERN_BYTES;
      end
      return int'(raw);
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(input int k);
      return pattern_cfg[k*BYTE_W +: BYTE_W];
   endfunction

   function automatic bit take_break();
      return !steady && ($urandom_range(99) < 38);
   endfunction

   function automatic void clear_region();
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         window_bytes[i] = '0;
      end
      region_offset  = '0;
      region_matched = 1'b0;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PATTERN_0_7:   pattern_cfg[0   +: 64] = value;
         CSR_PATTERN_8_15:  pattern_cfg[64  +: 64] = value;
         CSR_PATTERN_16_23: pattern_cfg[128 +: 64] = value;
         CSR_PATTERN_24_31: pattern_cfg[192 +: 64] = value;
         CSR_CARE_MASK:     care_cfg   = value[CARE_W-1:0];
         CSR_PATTERN_LEN:   length_cfg = value[LENGTH_W-1:0];
         CSR_BASE_ADDRESS:  base_cfg   = value;
         default: ;
      endcase
   endfunction

   // advance the region image by one byte and predict its report, if any
   function automatic void predict_scan(input req_word_type w);
      int          len;
      logic [31:0] count;
      bit          hit;
      bit          reported;
      rsp_word_type r;
      reported = 1'b0;
      if (!region_matched) begin
         len = active_length(length_cfg);
         for (int i = PATTERN_BYTES - 1; i > 0; i--) begin
            window_bytes[i] = window_bytes[i-1];
         end
         window_bytes[0] = w.data_byte;
         count = (region_offset == '1) ? region_offset : region_offset + 1;
         if (count >= 32'(len)) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++) begin
               if (care_cfg[k] && window_bytes[len-1-k] != pattern_byte(k)) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               r.found         = 1'b1;
               r.match_address = base_cfg + (64'(count) - 64'(len));
               predicted_reports.push_back(r);
               reported       = 1'b1;
               region_matched = 1'b1;
            end
         end
         region_offset = count;
         if (w.last_byte && !reported) begin
            r.found         = 1'b0;
            r.match_address = '0;
            predicted_reports.push_back(r);
         end
      end
      if (w.last_byte) begin
         clear_region();
      end
   endfunction

   function automatic void report_failure(input string what, input rsp_word_type want,
                                          input rsp_word_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected found=%0b addr=%h, got found=%0b addr=%h", what,
                  want.found, want.match_address, got.found, got.match_address);
      end
   endfunction

   // driver: hold a stalled word, otherwise offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_scan(req_word);
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (scan_words.size() != 0 && !take_break()) begin
               req_word  <= scan_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted report against the oldest prediction
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            reports_checked++;
            if (rsp_word.found === 1'b1) begin
               reports_found++;
            end
            if (predicted_reports.size() == 0) begin
               want = '0;
               report_failure("report with none predicted", want, rsp_word);
            end else begin
               want = predicted_reports.pop_front();
               if (rsp_word.found !== want.found ||
                   rsp_word.match_address !== want.match_address) begin
                  report_failure("report mismatch", want, rsp_word);
               end
            end
         end
         rsp_stall <= take_break();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run timed out after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic settle(input int extra);
      while (scan_words.size() != 0 || req_valid || predicted_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (extra) @(posedge clock);
   endtask

   task automatic load_settings(input logic [PATTERN_W-1:0] pat, input logic [CARE_W-1:0] care,
                                input logic [LENGTH_W-1:0] len, input logic [ADDR_W-1:0] base);
      logic [CSR_INDEX_W-1:0] order  [8];
      logic [CSR_DATA_W-1:0]  values [8];
      order  = '{CSR_PATTERN_0_7, CSR_PATTERN_8_15, CSR_PATTERN_16_23, CSR_PATTERN_24_31,
                 CSR_CARE_MASK, CSR_PATTERN_LEN, CSR_BASE_ADDRESS, CSR_UNMAPPED};
      values = '{pat[63:0], pat[127:64], pat[191:128], pat[255:192],
                 {32'($urandom), care}, {{26{1'b0}}, 32'($urandom), len}, base,
                 {32'($urandom), 32'($urandom)}};
      for (int r = 0; r < 8; r++) begin
         csr_index <= order[r];
         csr_wdata <= values[r];
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) begin
            @(posedge clock);
         end
         apply_csr(order[r], values[r]);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic queue_packed(input logic [255:0] seq, input int n);
      req_word_type w;
      for (int k = 0; k < n; k++) begin
         w.data_byte = seq[8*(n-1-k) +: 8];
         w.last_byte = (k == n - 1);
         scan_words.push_back(w);
         words_queued++;
      end
      regions_queued++;
   endtask

   // fill with random and pattern-like bytes, plant the pattern, sometimes break it
   task automatic queue_region(input int n, input bit plant);
      logic [BYTE_W-1:0] region_bytes [$];
      req_word_type      w;
      int                len;
      int                at;
      int                k;
      len = active_length(length_cfg);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(1) == 0) begin
            region_bytes.push_back(pattern_byte($urandom_range(len - 1)));
         end else begin
            region_bytes.push_back(8'($urandom_range(255)));
         end
      end
      if (plant && n >= len) begin
         at = $urandom_range(n - len);
         for (k = 0; k < len; k++) begin
            if (care_cfg[k]) begin
               region_bytes[at+k] = pattern_byte(k);
            end
         end
         if ($urandom_range(3) == 0) begin
            k = $urandom_range(len - 1);
            region_bytes[at+k] = region_bytes[at+k] ^ (8'h01 << $urandom_range(7));
         end
      end
      for (k = 0; k < n; k++) begin
         w.data_byte = region_bytes[k];
         w.last_byte = (k == n - 1);
         scan_words.push_back(w);
         words_queued++;
      end
      regions_queued++;
   endtask

   initial begin
      logic [PATTERN_W-1:0] pat;
      logic [CARE_W-1:0]    care;
      logic [LENGTH_W-1:0]  len;
      logic [ADDR_W-1:0]    base;
      int                   start_words;
      int                   n;
      clear_region();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one wildcard byte, every region hits at its first byte
      queue_packed(256'h00, 1);
      queue_packed(256'hFF_5A_A5, 3);
      settle(TAIL_CYCLES);

      // DE AD ?? EF near the top of the address space
      load_settings({{224{1'b0}}, 32'hEF_00_AD_DE}, 32'h0000_000B, 6'd4, '1 - 64'd1);
      queue_packed(256'h00_DE_DE_AD_77_EF_11, 7);
      queue_packed(256'hDE_AD, 2);
      queue_packed(256'hDE_AD_99_EF, 4);
      settle(TAIL_CYCLES);

      // zero length acts as one
      load_settings({{248{1'b1}}, 8'hFF}, '1, 6'd0, '0);
      queue_packed(256'h00_FF_80, 3);
      settle(TAIL_CYCLES);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         for (int i = 0; i < PATTERN_W / 32; i++) begin
            pat[i*32 +: 32] = $urandom;
         end
         care = $urandom;
         base = {32'($urandom), 32'($urandom)};
         len  = 6'($urandom_range(1, 12));
         case (phase)
            0: len = 6'd0;
            1: begin
               len  = 6'd32;
               care = '1;
               base = '1;
            end
            2: len = 6'd63;
            3: care = '0;
            4: begin
               len  = 6'($urandom_range(33, 62));
               base = '0;
            end
            default: ;
         endcase
         load_settings(pat, care, len, base);
         steady = (phase == 5);
         start_words = words_queued;
         while (words_queued - start_words < PHASE_WORDS) begin
            case ($urandom_range(9))
               0, 1, 2: n = $urandom_range(1, 6);
               9:       n = $urandom_range(40, 80);
               default: n = $urandom_range(active_length(len), active_length(len) + 16);
            endcase
            queue_region(n, $urandom_range(9) < 7);
         end
         settle(TAIL_CYCLES);
         steady = 1'b0;
      end

      settle(TAIL_CYCLES);
      $display("scanned %0d bytes in %0d regions under %0d register settings",
               words_accepted, regions_queued, settings_loaded);
      $display("checked %0d reports, %0d found, %0d mismatches",
               reports_checked, reports_found, mismatch_count);
      if (mismatch_count == 0 && predicted_reports.size() == 0 &&
          words_accepted == words_queued) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### wildcard_byte_pattern_scan_core.f
design/wbps_pkg.sv
design/wbps_csr.sv
design/wbps_engine.sv
design/wildcard_byte_pattern_scan_core.sv
tb/tb_wildcard_byte_pattern_scan_core.sv
